[src/flh64_pkg.sv]
// constants, command codes and helper functions shared by the hash block
package flh64_pkg;

  localparam logic [63:0] PHI_K  = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX1_K = 64'h85EBCA77C2B2AE3D;
  localparam logic [63:0] MIX2_K = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX3_K = 64'h94D049BB133111EB;

  localparam logic [5:0] BLOCK_ROT [8] = '{6'd11, 6'd43, 6'd19, 6'd53,
                                           6'd35, 6'd13, 6'd47, 6'd59};
  localparam logic [5:0] ROT_TAIL = 6'd11;

  localparam int unsigned FIN_SH0 = 29;
  localparam int unsigned FIN_SH1 = 31;
  localparam int unsigned FIN_SH2 = 37;
  localparam int unsigned FIN_SH3 = 41;

  localparam logic [5:0] NUM_LANES = 6'd4;

  // operand register load selection
  localparam logic [2:0] OP_HOLD  = 3'd0;
  localparam logic [2:0] OP_LEN   = 3'd1;
  localparam logic [2:0] OP_BASE  = 3'd2;
  localparam logic [2:0] OP_DATA  = 3'd3;
  localparam logic [2:0] OP_FOLD  = 3'd4;
  localparam logic [2:0] OP_MIX31 = 3'd5;
  localparam logic [2:0] OP_MIX37 = 3'd6;

  // multiplier constant selection
  localparam logic [1:0] MK_PHI  = 2'd0;
  localparam logic [1:0] MK_M1   = 2'd1;
  localparam logic [1:0] MK_M2   = 2'd2;
  localparam logic [1:0] MK_LANE = 2'd3;

  // partial product steps
  localparam logic [1:0] STEP_LL = 2'd0;
  localparam logic [1:0] STEP_LH = 2'd1;
  localparam logic [1:0] STEP_HL = 2'd2;

  typedef struct packed {
    logic [2:0] op_sel;
    logic       mul_en;
    logic [1:0] mul_step;
    logic [1:0] mul_k;
    logic       lane_wr;
    logic       lane_next;
    logic       out_load;
  } flh64_cmd_t;

  typedef struct packed {
    logic lane_last;
    logic len_zero;
    logic msg_last;
    logic msg_open;
    logic out_busy;
  } flh64_sts_t;

  function automatic logic [63:0] rotl64(input logic [63:0] v, input logic [5:0] r);
    logic [6:0] rs;
    rs = 7'd64 - {1'b0, r};
    return (v << r) | (v >> rs);
  endfunction

  function automatic logic [63:0] lane_const(input logic [1:0] sel);
    logic [63:0] k;
    unique case (sel)
      2'd0:    k = PHI_K;
      2'd1:    k = MIX1_K;
      2'd2:    k = MIX2_K;
      default: k = MIX3_K;
    endcase
    return k;
  endfunction

endpackage

[src/flh64_if.sv]
// valid/ready stream interfaces for the input items and the hash results
interface flh64_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [63:0] seed;
  logic [31:0] message_length;
  logic [63:0] data_word;

  modport source (output valid, output action, output seed, output message_length,
                  output data_word, input ready);
  modport sink (input valid, input action, input seed, input message_length,
                input data_word, output ready);
endinterface

interface flh64_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink (input valid, input hash_value, output ready);
endinterface

[src/flh64_datapath.sv]
// lane registers, shared 32x32 multiplier, finaliser mixing and result register
module flh64_datapath import flh64_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  flh64_cmd_t  cmd_i,
  output flh64_sts_t  sts_o,
  input  logic [63:0] seed_i,
  input  logic [31:0] message_length_i,
  input  logic [63:0] data_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] hash_value_o
);

  logic [63:0] lanes_q [4];
  logic [63:0] seed_q;
  logic [31:0] len_q;
  logic [31:0] off_q;
  logic        open_q;
  logic [63:0] op_q;
  logic [63:0] acc_q;
  logic [1:0]  lane_sel_q;
  logic        last_q;
  logic        out_valid_q;
  logic [63:0] hash_q;

  logic [63:0] kconst;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [63:0] acc_d;

  logic [31:0] block_end;
  logic        in_block;
  logic [32:0] nxt;
  logic        tail;
  logic        last_d;
  logic [63:0] byte_mask;
  logic [63:0] word_m;
  logic [5:0]  rot;
  logic [1:0]  dsel;
  logic [63:0] data_op;
  logic [63:0] fold;
  logic [63:0] fold_op;
  logic [63:0] mix31_op;
  logic [63:0] mix37_op;
  logic [63:0] res;

  // multiplier: low 64 bits of op times constant in three partial products
  always_comb begin
    if (cmd_i.mul_k == MK_LANE) begin
      kconst = lane_const(lane_sel_q);
    end else if (cmd_i.mul_k == MK_M1) begin
      kconst = MIX1_K;
    end else if (cmd_i.mul_k == MK_M2) begin
      kconst = MIX2_K;
    end else begin
      kconst = PHI_K;
    end
    mul_a = (cmd_i.mul_step == STEP_HL) ? op_q[63:32] : op_q[31:0];
    mul_b = (cmd_i.mul_step == STEP_LH) ? kconst[63:32] : kconst[31:0];
    prod  = {32'b0, mul_a} * {32'b0, mul_b};
    unique case (cmd_i.mul_step)
      STEP_LL: acc_d = prod;
      STEP_LH: acc_d = acc_q + {prod[31:0], 32'b0};
      STEP_HL: acc_d = acc_q + {prod[31:0], 32'b0};
      default: acc_d = acc_q;
    endcase
  end

  // word placement within the message
  always_comb begin
    block_end = {len_q[31:6], 6'b0};
    in_block  = off_q < block_end;
    nxt       = {1'b0, off_q} + 33'd8;
    tail      = !in_block && (nxt > {1'b0, len_q});
    last_d    = nxt >= {1'b0, len_q};
    for (int b = 0; b < 8; b++) begin
      byte_mask[b*8 +: 8] = (3'(b) < len_q[2:0]) ? 8'hFF : 8'h00;
    end
    word_m  = tail ? (data_word_i & byte_mask) : data_word_i;
    rot     = in_block ? BLOCK_ROT[off_q[5:3]] : ROT_TAIL;
    dsel    = in_block ? off_q[5:4] : 2'd0;
    data_op = lanes_q[dsel] ^ rotl64(word_m, rot);
  end

  always_comb begin
    fold     = lanes_q[0] ^ lanes_q[1] ^ lanes_q[2] ^ lanes_q[3];
    fold_op  = fold ^ (fold >> FIN_SH0);
    mix31_op = acc_d ^ (acc_d >> FIN_SH1);
    mix37_op = acc_d ^ (acc_d >> FIN_SH2);
    res      = acc_d ^ (acc_d >> FIN_SH3);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      acc_q <= acc_d;
    end
    if (cmd_i.lane_wr) begin
      lanes_q[lane_sel_q] <= acc_d;
    end
    if (cmd_i.out_load) begin
      hash_q <= res;
    end
    unique case (cmd_i.op_sel)
      OP_LEN: begin
        seed_q <= seed_i;
        op_q   <= {32'b0, message_length_i};
      end
      OP_BASE:  op_q <= seed_q ^ acc_d;
      OP_DATA: begin
        op_q   <= data_op;
        last_q <= last_d;
      end
      OP_FOLD:  op_q <= fold_op;
      OP_MIX31: op_q <= mix31_op;
      OP_MIX37: op_q <= mix37_op;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      off_q       <= '0;
      open_q      <= 1'b0;
      lane_sel_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op_sel == OP_LEN) begin
        len_q      <= message_length_i;
        off_q      <= '0;
        open_q     <= message_length_i != 32'd0;
        lane_sel_q <= '0;
      end else if (cmd_i.op_sel == OP_DATA) begin
        lane_sel_q <= dsel;
        if (last_d) begin
          open_q <= 1'b0;
          off_q  <= '0;
        end else begin
          off_q <= nxt[31:0];
        end
      end else if (cmd_i.lane_next) begin
        lane_sel_q <= lane_sel_q + 2'd1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.lane_last = {4'b0, lane_sel_q} == (NUM_LANES - 6'd1);
  assign sts_o.len_zero  = len_q == 32'd0;
  assign sts_o.msg_last  = last_q;
  assign sts_o.msg_open  = open_q;
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

endmodule

[src/flh64_ctrl.sv]
// sequencer for message start, word absorption and the finaliser
module flh64_ctrl import flh64_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_action_i,
  output logic       in_ready_o,
  input  flh64_sts_t sts_i,
  output flh64_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_LEN_MUL  = 3'd1;
  localparam logic [2:0] ST_LANE_MUL = 3'd2;
  localparam logic [2:0] ST_DATA_MUL = 3'd3;
  localparam logic [2:0] ST_FOLD     = 3'd4;
  localparam logic [2:0] ST_FIN_MUL  = 3'd5;

  localparam logic [1:0] FIN_M1  = 2'd0;
  localparam logic [1:0] FIN_M2  = 2'd1;
  localparam logic [1:0] FIN_PHI = 2'd2;

  localparam logic ACT_START = 1'b0;

  logic [2:0] state_q, state_d;
  logic [1:0] step_q, step_d;
  logic [1:0] fin_q, fin_d;
  logic       step_end;

  assign step_end = step_q == STEP_HL;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    fin_d   = fin_q;
    cmd_o   = '0;
    cmd_o.op_sel   = OP_HOLD;
    cmd_o.mul_step = step_q;
    cmd_o.mul_k    = MK_PHI;
    in_ready_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        step_d     = STEP_LL;
        if (in_valid_i) begin
          if (in_action_i == ACT_START) begin
            cmd_o.op_sel = OP_LEN;
            state_d      = ST_LEN_MUL;
          end else if (sts_i.msg_open) begin
            cmd_o.op_sel = OP_DATA;
            state_d      = ST_DATA_MUL;
          end
        end
      end
      ST_LEN_MUL: begin
        cmd_o.mul_en = 1'b1;
        if (step_end) begin
          cmd_o.op_sel = OP_BASE;
          state_d      = ST_LANE_MUL;
        end
      end
      ST_LANE_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_k  = MK_LANE;
        if (step_end) begin
          cmd_o.lane_wr = 1'b1;
          if (sts_i.lane_last) begin
            state_d = sts_i.len_zero ? ST_FOLD : ST_IDLE;
          end else begin
            cmd_o.lane_next = 1'b1;
          end
        end
      end
      ST_DATA_MUL: begin
        cmd_o.mul_en = 1'b1;
        if (step_end) begin
          cmd_o.lane_wr = 1'b1;
          state_d       = sts_i.msg_last ? ST_FOLD : ST_IDLE;
        end
      end
      ST_FOLD: begin
        cmd_o.op_sel = OP_FOLD;
        fin_d        = FIN_M1;
        step_d       = STEP_LL;
        state_d      = ST_FIN_MUL;
      end
      ST_FIN_MUL: begin
        cmd_o.mul_en = 1'b1;
        unique case (fin_q)
          FIN_M1:  cmd_o.mul_k = MK_M1;
          FIN_M2:  cmd_o.mul_k = MK_M2;
          default: cmd_o.mul_k = MK_PHI;
        endcase
        if (step_end) begin
          unique case (fin_q)
            FIN_M1: begin
              cmd_o.op_sel = OP_MIX31;
              fin_d        = FIN_M2;
            end
            FIN_M2: begin
              cmd_o.op_sel = OP_MIX37;
              fin_d        = FIN_PHI;
            end
            default: begin
              // hold the last step until the result register is free
              if (sts_i.out_busy) begin
                cmd_o.mul_en = 1'b0;
              end else begin
                cmd_o.out_load = 1'b1;
                state_d        = ST_IDLE;
              end
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (cmd_o.mul_en) begin
      step_d = step_end ? STEP_LL : step_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= STEP_LL;
      fin_q   <= FIN_M1;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      fin_q   <= fin_d;
    end
  end

  a_out_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !sts_i.out_busy)
    else $error("result loaded while result register occupied");

  a_lane_wr_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.lane_wr |-> (cmd_o.mul_en && cmd_o.mul_step == STEP_HL))
    else $error("lane written outside final partial product");

  a_step_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.mul_en && step_end) |=> step_q == STEP_LL)
    else $error("multiply step counter did not wrap");

  a_idle_no_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!cmd_o.mul_en && !cmd_o.lane_wr))
    else $error("multiplier active while waiting for input");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q != 2'd3)
    else $error("multiply step counter out of range");

endmodule

[src/four_lane_hash64_dual_rotation.sv]
// Streaming 64-bit four-lane message hash, top level. Input items are taken only while the
// sequencer waits for work. A data word is taken in, then goes through three partial-product
// steps of the single shared 32x32 multiplier that form the 64-bit lane product. A start item
// is followed by one length multiply and four lane multiplies of three steps each; data with
// no message open is taken and dropped. The word with the last byte of a message adds folding
// and the three finaliser multiplies, and the last of these waits while an earlier hash still
// sits untaken in the result register. A zero-length start goes from the lane multiplies
// straight to folding. The result register lets the next item be taken while a hash waits.
module four_lane_hash64_dual_rotation import flh64_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  flh64_in_if.sink    in_i,
  flh64_out_if.source out_o
);

  flh64_cmd_t cmd;
  flh64_sts_t sts;

  flh64_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  flh64_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .seed_i           (in_i.seed),
    .message_length_i (in_i.message_length),
    .data_word_i      (in_i.data_word),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .hash_value_o     (out_o.hash_value)
  );

endmodule
